/* design/mgr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mgr_pkg : gesture recognizer shared definitions
// Constants, word types, controller command/status and small helpers.
// ----------------------------------------------------------------------------
package mgr_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int COORD_BITS = 12;
	localparam int CFG_W      = 12;
	localparam int FINGER_W   = 5;
	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int SUM_W      = COORD_BITS + IDX_W;
	localparam int DIV_CW     = $clog2(SUM_W + 1);
	localparam int CMP_W      = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
	localparam int ENT_W      = 4 * COORD_BITS;

	localparam logic [CFG_W-1:0] START_DIST_RST = CFG_W'(60);

	localparam logic [1:0] EV_DOWN = 2'd0;
	localparam logic [1:0] EV_MOVE = 2'd1;
	localparam logic [1:0] EV_UP   = 2'd2;

	localparam logic [1:0] GK_TAP   = 2'd0;
	localparam logic [1:0] GK_SWIPE = 2'd1;
	localparam logic [1:0] GK_PINCH = 2'd2;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;
	localparam logic [1:0] DIR_IN    = 2'd0;

	typedef struct packed {
		logic [1:0]            event_kind;
		logic [3:0]            slot_index;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
	} in_word_t;

	typedef struct packed {
		logic [1:0]            gesture_kind;
		logic [1:0]            direction;
		logic [FINGER_W-1:0]   finger_count;
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] end_y;
	} out_word_t;

	typedef struct packed {
		logic capture;
		logic do_down;
		logic do_up;
		logic do_move;
		logic scan_init;
		logic scan_rd;
		logic div_init;
		logic div_step;
		logic hold;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       slot_ok;
		logic       start_hit;
		logic       scan_last;
		logic       div_done;
		logic       last_lift;
		logic       out_free;
	} ctrl_sts_t;

	function automatic logic [FINGER_W-1:0] sat_fingers(input logic [CNT_W-1:0] c);
		logic [FINGER_W-1:0] r;
		if (int'(c) > 31) begin
			r = '1;
		end else begin
			r = FINGER_W'(c);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/mgr_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mgr_ram : generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* design/mgr_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mgr_ctrl : gesture recognizer sequencer
// Steps each event through decode, slot update, slot scan, divide and result.
// ----------------------------------------------------------------------------
module mgr_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire mgr_pkg::ctrl_sts_t sts,
	output mgr_pkg::ctrl_cmd_t      cmd
);
	import mgr_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECODE  = 4'd1;
	localparam logic [3:0] S_MOVE    = 4'd2;
	localparam logic [3:0] S_SCAN    = 4'd3;
	localparam logic [3:0] S_DRAIN   = 4'd4;
	localparam logic [3:0] S_DIVINIT = 4'd5;
	localparam logic [3:0] S_DIV     = 4'd6;
	localparam logic [3:0] S_HOLD    = 4'd7;
	localparam logic [3:0] S_UP      = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_DECODE;
				end
			end
			S_DECODE: begin
				state_nxt = S_IDLE;
				if (sts.slot_ok) begin
					case (sts.kind)
						EV_DOWN: begin
							cmd.do_down = 1'b1;
						end
						EV_MOVE: begin
							state_nxt = S_MOVE;
						end
						EV_UP: begin
							cmd.do_up = 1'b1;
							state_nxt = S_UP;
						end
						default: begin
							state_nxt = S_IDLE;
						end
					endcase
				end
			end
			S_MOVE: begin
				cmd.do_move = 1'b1;
				if (sts.start_hit) begin
					cmd.scan_init = 1'b1;
					state_nxt     = S_SCAN;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nxt = S_DIVINIT;
			end
			S_DIVINIT: begin
				cmd.div_init = 1'b1;
				state_nxt    = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_nxt = S_HOLD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_HOLD: begin
				cmd.hold  = 1'b1;
				state_nxt = S_IDLE;
			end
			S_UP: begin
				if (!sts.last_lift) begin
					state_nxt = S_IDLE;
				end else if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

/* design/mgr_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mgr_dp : gesture recognizer datapath
// Slot store, active flags, scan accumulators, serial divider, held gesture
// and the output word register.
// ----------------------------------------------------------------------------
module mgr_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mgr_pkg::in_word_t           in_word,
	input  wire logic                        cfg_we,
	input  wire logic [mgr_pkg::CFG_W-1:0]   cfg_data,
	input  wire mgr_pkg::ctrl_cmd_t          cmd,
	output mgr_pkg::ctrl_sts_t               sts,
	output logic                             out_valid,
	output mgr_pkg::out_word_t               out_word,
	input  wire logic                        out_stall
);
	import mgr_pkg::*;

	localparam int C = COORD_BITS;

	function automatic logic [C-1:0] abs_d(input logic signed [C:0] v);
		logic [C:0] m;
		m = v[C] ? (~v + 1'b1) : v;
		return m[C-1:0];
	endfunction

	function automatic logic [CNT_W+SUM_W-1:0] div_stage(input logic [CNT_W-1:0] rem,
		input logic [SUM_W-1:0] q, input logic [CNT_W-1:0] d);
		logic [CNT_W:0]   sh;
		logic [CNT_W:0]   diff;
		logic [CNT_W-1:0] rem_n;
		logic             qb;
		sh   = {rem, q[SUM_W-1]};
		diff = sh - {1'b0, d};
		if (sh >= {1'b0, d}) begin
			rem_n = diff[CNT_W-1:0];
			qb    = 1'b1;
		end else begin
			rem_n = sh[CNT_W-1:0];
			qb    = 1'b0;
		end
		return {rem_n, q[SUM_W-2:0], qb};
	endfunction

	// item registers
	logic [1:0]       kind_q;
	logic [3:0]       slot_q;
	logic [C-1:0]     px_q;
	logic [C-1:0]     py_q;
	logic [IDX_W-1:0] sid;

	// control state
	logic [CFG_W-1:0]      dist_q;
	logic [SLOT_COUNT-1:0] active_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [FINGER_W-1:0]   tap_q;
	logic                  started_q;
	logic [1:0]            held_kind_q;
	logic [1:0]            held_dir_q;
	logic [FINGER_W-1:0]   held_fingers_q;
	logic [C-1:0]          held_sx_q;
	logic [C-1:0]          held_sy_q;
	logic                  out_valid_q;
	out_word_t             out_word_q;

	// scan and divide
	logic [IDX_W-1:0]      idx_q;
	logic                  acc_vld_s1;
	logic [IDX_W-1:0]      acc_idx_s1;
	logic [SUM_W-1:0]      sum_x_q;
	logic [SUM_W-1:0]      sum_y_q;
	logic                  xpos_q, xneg_q, ypos_q, yneg_q;
	logic signed [C:0]     dx_q;
	logic signed [C:0]     dy_q;
	logic [SUM_W-1:0]      qx_q;
	logic [SUM_W-1:0]      qy_q;
	logic [CNT_W-1:0]      rx_q;
	logic [CNT_W-1:0]      ry_q;
	logic [CNT_W-1:0]      dvs_q;
	logic [DIV_CW-1:0]     div_cnt_q;

	// ram
	logic             ram_we;
	logic [ENT_W-1:0] ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [ENT_W-1:0] ram_rdata;
	logic [C-1:0]     r_sx, r_sy, r_cx, r_cy;

	logic signed [C:0]     dx;
	logic signed [C:0]     dy;
	logic signed [C:0]     ddx;
	logic signed [C:0]     ddy;
	logic [CNT_W-1:0]      cnt_inc;
	logic [CNT_W+SUM_W-1:0] stage_x;
	logic [CNT_W+SUM_W-1:0] stage_y;
	logic                  swipe;

	assign sid = IDX_W'(slot_q);

	assign r_sx = ram_rdata[4*C-1:3*C];
	assign r_sy = ram_rdata[3*C-1:2*C];
	assign r_cx = ram_rdata[2*C-1:C];
	assign r_cy = ram_rdata[C-1:0];

	assign ram_we    = cmd.do_down | cmd.do_move;
	assign ram_wdata = cmd.do_down ? {px_q, py_q, px_q, py_q} : {r_sx, r_sy, px_q, py_q};
	assign ram_raddr = cmd.scan_rd ? idx_q : sid;

	mgr_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(sid),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign dx  = $signed({1'b0, px_q}) - $signed({1'b0, r_sx});
	assign dy  = $signed({1'b0, py_q}) - $signed({1'b0, r_sy});
	assign ddx = $signed({1'b0, r_cx}) - $signed({1'b0, r_sx});
	assign ddy = $signed({1'b0, r_cy}) - $signed({1'b0, r_sy});

	assign cnt_inc = cnt_q + CNT_W'(!active_q[sid]);
	assign stage_x = div_stage(rx_q, qx_q, dvs_q);
	assign stage_y = div_stage(ry_q, qy_q, dvs_q);
	assign swipe   = xpos_q | xneg_q | ypos_q | yneg_q;

	always_comb begin
		sts.kind      = kind_q;
		sts.slot_ok   = int'(slot_q) < SLOT_COUNT;
		sts.start_hit = !started_q && (cnt_q >= CNT_W'(2)) &&
			((CMP_W'(abs_d(dx)) >= CMP_W'(dist_q)) || (CMP_W'(abs_d(dy)) >= CMP_W'(dist_q)));
		sts.scan_last = (idx_q == IDX_W'(SLOT_COUNT - 1));
		sts.div_done  = (div_cnt_q == DIV_CW'(SUM_W));
		sts.last_lift = (cnt_q == '0);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q         <= START_DIST_RST;
			active_q       <= '0;
			cnt_q          <= '0;
			tap_q          <= '0;
			started_q      <= 1'b0;
			held_kind_q    <= '0;
			held_dir_q     <= '0;
			held_fingers_q <= '0;
			held_sx_q      <= '0;
			held_sy_q      <= '0;
			out_valid_q    <= 1'b0;
			acc_vld_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				dist_q <= cfg_data;
			end
			acc_vld_s1 <= cmd.scan_rd;
			if (cmd.do_down) begin
				active_q[sid] <= 1'b1;
				cnt_q         <= cnt_inc;
				tap_q         <= sat_fingers(cnt_inc);
			end
			if (cmd.do_up) begin
				active_q[sid] <= 1'b0;
				if (active_q[sid]) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (cmd.hold) begin
				started_q      <= 1'b1;
				held_fingers_q <= sat_fingers(cnt_q);
				held_sx_q      <= qx_q[C-1:0];
				held_sy_q      <= qy_q[C-1:0];
				if (swipe) begin
					held_kind_q <= GK_SWIPE;
					if (abs_d(dx_q) > abs_d(dy_q)) begin
						held_dir_q <= (dx_q > 0) ? DIR_RIGHT : DIR_LEFT;
					end else begin
						held_dir_q <= (dy_q > 0) ? DIR_DOWN : DIR_UP;
					end
				end else begin
					held_kind_q <= GK_PINCH;
					held_dir_q  <= DIR_IN;
				end
			end
			if (cmd.emit) begin
				started_q   <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_word.event_kind;
			slot_q <= in_word.slot_index;
			px_q   <= in_word.pos_x;
			py_q   <= in_word.pos_y;
		end
		if (cmd.do_move) begin
			dx_q <= dx;
			dy_q <= dy;
		end
		if (cmd.scan_init) begin
			idx_q   <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			xpos_q  <= 1'b1;
			xneg_q  <= 1'b1;
			ypos_q  <= 1'b1;
			yneg_q  <= 1'b1;
		end else begin
			if (cmd.scan_rd) begin
				idx_q <= idx_q + 1'b1;
			end
			if (acc_vld_s1 && active_q[acc_idx_s1]) begin
				sum_x_q <= sum_x_q + SUM_W'(r_sx);
				sum_y_q <= sum_y_q + SUM_W'(r_sy);
				if (ddx < 0) xpos_q <= 1'b0;
				if (ddx > 0) xneg_q <= 1'b0;
				if (ddy < 0) ypos_q <= 1'b0;
				if (ddy > 0) yneg_q <= 1'b0;
			end
		end
		acc_idx_s1 <= idx_q;
		if (cmd.div_init) begin
			qx_q      <= sum_x_q;
			qy_q      <= sum_y_q;
			rx_q      <= '0;
			ry_q      <= '0;
			dvs_q     <= (cnt_q == '0) ? CNT_W'(1) : cnt_q;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			{rx_q, qx_q} <= stage_x;
			{ry_q, qy_q} <= stage_y;
			div_cnt_q    <= div_cnt_q + 1'b1;
		end
		if (cmd.emit) begin
			if (!started_q) begin
				out_word_q.gesture_kind <= GK_TAP;
				out_word_q.direction    <= DIR_IN;
				out_word_q.finger_count <= tap_q;
				out_word_q.start_x      <= r_sx;
				out_word_q.start_y      <= r_sy;
				out_word_q.end_x        <= '0;
				out_word_q.end_y        <= '0;
			end else begin
				out_word_q.gesture_kind <= held_kind_q;
				out_word_q.direction    <= held_dir_q;
				out_word_q.finger_count <= held_fingers_q;
				out_word_q.start_x      <= held_sx_q;
				out_word_q.start_y      <= held_sy_q;
				out_word_q.end_x        <= (held_kind_q == GK_SWIPE) ? px_q : '0;
				out_word_q.end_y        <= (held_kind_q == GK_SWIPE) ? py_q : '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
`default_nettype wire

/* design/multitouch_gesture_recognizer_core.sv */
// Result: on the last lift the output word is registered from the up state once the
//   output register is free. Input: one event at a time; the next word is taken only
//   once the sequencer is back in idle, and a move that starts a gesture first runs
//   a slot RAM scan, then a bit-serial divide for the mean start point.
// Stalls: a result finding the output register full and stalled holds off the input.
// Reset: arst_n clears slot flags, finger count, gesture state and output valid.
`default_nettype none
// ----------------------------------------------------------------------------
// multitouch_gesture_recognizer_core : multi-touch gesture recognizer
// Tracks contact slots and reports tap, swipe or pinch on the last lift.
// ----------------------------------------------------------------------------
module multitouch_gesture_recognizer_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire mgr_pkg::in_word_t         in_word,
	output logic                           in_stall,
	output logic                           out_valid,
	output mgr_pkg::out_word_t             out_word,
	input  wire logic                      out_stall,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [mgr_pkg::CFG_W-1:0] cfg_data
);
	import mgr_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	mgr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	mgr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_word (out_word),
		.out_stall(out_stall)
	);

endmodule
`default_nettype wire

/* design/mgr_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mgr_chk : gesture recognizer port checker
// Watches the top level ports; bound to the core.
// ----------------------------------------------------------------------------
module mgr_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire mgr_pkg::out_word_t out_word,
	input wire logic               out_stall
);
	import mgr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accepted word");

	a_tap_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.gesture_kind == GK_TAP |->
		out_word.direction == DIR_IN && out_word.end_x == '0 && out_word.end_y == '0)
		else $error("tap with direction or end point");

	a_pinch_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.gesture_kind == GK_PINCH |->
		out_word.direction == DIR_IN && out_word.end_x == '0 && out_word.end_y == '0)
		else $error("pinch with direction or end point");

	a_multi_finger: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.gesture_kind != GK_TAP |-> out_word.finger_count >= 2)
		else $error("swipe or pinch with fewer than two fingers");

endmodule

bind multitouch_gesture_recognizer_core mgr_chk u_mgr_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_word (out_word),
	.out_stall(out_stall)
);
`default_nettype wire
